[rtl/twp_pkg.sv]
package twp_pkg;

   // sizing of the block
   localparam int MAX_ITEMS   = 32;
   localparam int MAX_DIFF    = 64;
   localparam int WEIGHT_BITS = 10;
   localparam int BINS        = 3;

   // derived widths
   localparam int DIFF_BITS   = $clog2(MAX_DIFF);
   localparam int LAYER_BITS  = $clog2(MAX_ITEMS + 1);
   localparam int ITEM_AW     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int VAL_BITS    = WEIGHT_BITS + DIFF_BITS + 1;
   localparam int LINK_BITS   = 2 * DIFF_BITS + 2;
   localparam int REACH_DEPTH = (MAX_ITEMS + 1) * MAX_DIFF;
   localparam int REACH_AW    = $clog2(REACH_DEPTH);
   localparam int LINK_DEPTH  = (MAX_ITEMS + 1) * MAX_DIFF * MAX_DIFF;
   localparam int LINK_AW     = $clog2(LINK_DEPTH);

   // fixed result field widths
   localparam int INDEX_BITS  = 5;
   localparam int GROUP_BITS  = 2;
   localparam int SPREAD_BITS = 7;

   typedef logic [1:0] slot_type;

   localparam slot_type SLOT_LAST = 2'd2;

   // outcome of placing one item into one bin of a gap pair
   typedef struct packed {
      logic [DIFF_BITS-1:0]    n1;
      logic [DIFF_BITS-1:0]    n2;
      logic                    ok;
      slot_type                home;
      slot_type [BINS-1:0]     rank;
   } place_type;

endpackage

[rtl/twp_place.sv]
module twp_place import twp_pkg::*; (
   input  logic [DIFF_BITS-1:0]   d1,
   input  logic [DIFF_BITS-1:0]   d2,
   input  slot_type               slot,
   input  logic [WEIGHT_BITS-1:0] weight,
   output place_type              res
);

   // add the weight to one sorted bin, re-rank stably and take the new gaps
   always_comb begin
      logic [VAL_BITS-1:0] v [BINS];
      logic [VAL_BITS-1:0] s [BINS];
      slot_type            r [BINS];
      slot_type            p_eff;
      logic [VAL_BITS-1:0] g1;
      logic [VAL_BITS-1:0] g2;

      p_eff = (slot > SLOT_LAST) ? 2'd0 : slot;
      v[0] = '0;
      v[1] = VAL_BITS'(d1);
      v[2] = VAL_BITS'(d1) + VAL_BITS'(d2);
      v[p_eff] = v[p_eff] + VAL_BITS'(weight);

      for (int j = 0; j < BINS; j++) begin
         r[j] = '0;
         for (int k = 0; k < BINS; k++) begin
            if (v[k] < v[j] || (v[k] == v[j] && k < j)) begin
               r[j] = r[j] + 2'd1;
            end
         end
      end

      for (int j = 0; j < BINS; j++) begin
         s[j] = '0;
      end
      for (int j = 0; j < BINS; j++) begin
         s[r[j]] = v[j];
      end

      g1 = s[1] - s[0];
      g2 = s[2] - s[1];

      res.ok   = (g1 < VAL_BITS'(MAX_DIFF)) && (g2 < VAL_BITS'(MAX_DIFF));
      res.n1   = g1[DIFF_BITS-1:0];
      res.n2   = g2[DIFF_BITS-1:0];
      res.home = r[p_eff];
      for (int j = 0; j < BINS; j++) begin
         res.rank[j] = r[j];
      end
   end

endmodule

[rtl/three_way_partition_dp.sv]
// Three-way partition of up to 32 weights by a gap-pair reach table. Each
// request is one weight; while a run is in progress a request is taken
// only when the block is idle. An item is taken, its layer is cleared
// one row at a time, then each of the 64 rows is fetched; a gap
// position whose bit is clear is skipped, and one whose bit is set
// tries each of the three bins. The pace is set by the single read and
// write port of the reach memory, through which every kept placement
// does a read-modify-write of one row. On the item marked last the block
// scans the final layer, traces the parent links back one item at a time
// and then delivers one response per stored item in arrival order. Items
// beyond capacity are dropped and flag overflow. No clearing pass follows
// reset: the origin layer is produced by logic.
module three_way_partition_dp import twp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [WEIGHT_BITS-1:0] req_weight,
   input  logic                   req_last_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [INDEX_BITS-1:0]  rsp_item_index,
   output logic [GROUP_BITS-1:0]  rsp_group,
   output logic [SPREAD_BITS-1:0] rsp_spread,
   output logic                   rsp_no_solution,
   output logic                   rsp_overflow,
   output logic                   rsp_last_result
);

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_CLEAR = 12'b0000_0000_0010,
      S_FRD   = 12'b0000_0000_0100,
      S_FROW  = 12'b0000_0000_1000,
      S_FSTEP = 12'b0000_0001_0000,
      S_FWR   = 12'b0000_0010_0000,
      S_BRD   = 12'b0000_0100_0000,
      S_BROW  = 12'b0000_1000_0000,
      S_BSTEP = 12'b0001_0000_0000,
      S_TRD   = 12'b0010_0000_0000,
      S_TSTEP = 12'b0100_0000_0000,
      S_EMIT  = 12'b1000_0000_0000
   } state_type;

   localparam logic [DIFF_BITS-1:0] DIFF_LAST = DIFF_BITS'(MAX_DIFF - 1);

   function automatic logic [REACH_AW-1:0] reach_addr(
      input logic [LAYER_BITS-1:0] layer,
      input logic [DIFF_BITS-1:0]  row
   );
      return REACH_AW'(int'(layer) * MAX_DIFF + int'(row));
   endfunction

   function automatic logic [LINK_AW-1:0] link_addr(
      input logic [LAYER_BITS-1:0] layer,
      input logic [DIFF_BITS-1:0]  n1,
      input logic [DIFF_BITS-1:0]  n2
   );
      return LINK_AW'((int'(layer) * MAX_DIFF + int'(n1)) * MAX_DIFF + int'(n2));
   endfunction

   // memories
   logic [MAX_DIFF-1:0]  reach_mem [REACH_DEPTH];
   logic [LINK_BITS-1:0] link_mem  [LINK_DEPTH];
   logic [MAX_DIFF-1:0]  reach_rd_ff;
   logic [LINK_BITS-1:0] link_rd_ff;

   logic                 reach_re;
   logic [REACH_AW-1:0]  reach_raddr;
   logic                 reach_we;
   logic [REACH_AW-1:0]  reach_waddr;
   logic [MAX_DIFF-1:0]  reach_wdata;
   logic                 link_re;
   logic [LINK_AW-1:0]   link_raddr;
   logic                 link_we;
   logic [LINK_AW-1:0]   link_waddr;

   // small stores in flops
   logic [WEIGHT_BITS-1:0] weights_ff [MAX_ITEMS];
   slot_type               grp_ff     [MAX_ITEMS];
   logic                   wt_we;
   logic                   grp_we;
   logic [ITEM_AW-1:0]     grp_idx;
   slot_type               grp_val;

   // control and datapath registers
   state_type              state_ff, state_in;
   logic [LAYER_BITS-1:0]  count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic                   last_ff, last_in;
   logic [WEIGHT_BITS-1:0] weight_ff, weight_in;
   logic [LAYER_BITS-1:0]  layer_ff, layer_in;
   logic                   layer0_ff, layer0_in;
   logic [DIFF_BITS-1:0]   d1_ff, d1_in;
   logic [DIFF_BITS-1:0]   d2_ff, d2_in;
   slot_type               slot_ff, slot_in;
   logic [MAX_DIFF-1:0]    row_ff, row_in;
   logic [DIFF_BITS-1:0]   tgt_n1_ff, tgt_n1_in;
   logic [DIFF_BITS-1:0]   tgt_n2_ff, tgt_n2_in;
   logic [LINK_BITS-1:0]   tgt_link_ff, tgt_link_in;
   logic                   found_ff, found_in;
   logic [DIFF_BITS:0]     best_ff, best_in;
   logic [DIFF_BITS-1:0]   bd1_ff, bd1_in;
   logic [DIFF_BITS-1:0]   bd2_ff, bd2_in;
   slot_type [BINS-1:0]    lab_ff, lab_in;
   logic [LAYER_BITS-1:0]  eidx_ff, eidx_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0]  rsp_idx_ff, rsp_idx_in;
   slot_type               rsp_grp_ff, rsp_grp_in;
   logic [SPREAD_BITS-1:0] rsp_spread_ff, rsp_spread_in;
   logic                   rsp_nosol_ff, rsp_nosol_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;
   logic                   rsp_last_ff, rsp_last_in;

   // placement unit, shared by forward fill and trace back
   logic [DIFF_BITS-1:0]   pl_d1;
   logic [DIFF_BITS-1:0]   pl_d2;
   slot_type               pl_slot;
   logic [WEIGHT_BITS-1:0] pl_weight;
   place_type              pl_res;
   logic [ITEM_AW-1:0]     tr_idx;
   logic [MAX_DIFF-1:0]    row_src;
   logic [DIFF_BITS:0]     pair_sum;
   logic                   out_free;
   logic                   adv;
   logic                   adv_skip;

   assign tr_idx = ITEM_AW'(layer_ff - 1'b1);

   always_comb begin
      if (state_ff == S_TSTEP) begin
         pl_d1     = link_rd_ff[LINK_BITS-1 -: DIFF_BITS];
         pl_d2     = link_rd_ff[2 +: DIFF_BITS];
         pl_slot   = link_rd_ff[1:0];
         pl_weight = weights_ff[tr_idx];
      end else begin
         pl_d1     = d1_ff;
         pl_d2     = d2_ff;
         pl_slot   = slot_ff;
         pl_weight = weight_ff;
      end
   end

   twp_place u_place (
      .d1     (pl_d1),
      .d2     (pl_d2),
      .slot   (pl_slot),
      .weight (pl_weight),
      .res    (pl_res)
   );

   // origin layer comes from logic, later layers from the memory
   assign row_src  = layer0_ff ? ((d1_ff == '0) ? MAX_DIFF'(1) : '0) : reach_rd_ff;
   assign pair_sum = {1'b0, d1_ff} + {1'b0, d2_ff};
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      last_in       = last_ff;
      weight_in     = weight_ff;
      layer_in      = layer_ff;
      layer0_in     = layer0_ff;
      d1_in         = d1_ff;
      d2_in         = d2_ff;
      slot_in       = slot_ff;
      row_in        = row_ff;
      tgt_n1_in     = tgt_n1_ff;
      tgt_n2_in     = tgt_n2_ff;
      tgt_link_in   = tgt_link_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      bd1_in        = bd1_ff;
      bd2_in        = bd2_ff;
      lab_in        = lab_ff;
      eidx_in       = eidx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_grp_in    = rsp_grp_ff;
      rsp_spread_in = rsp_spread_ff;
      rsp_nosol_in  = rsp_nosol_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_last_in   = rsp_last_ff;

      reach_re    = 1'b0;
      reach_raddr = reach_addr(layer_ff, d1_ff);
      reach_we    = 1'b0;
      reach_waddr = reach_addr(layer_ff + 1'b1, d1_ff);
      reach_wdata = '0;
      link_re     = 1'b0;
      link_raddr  = link_addr(layer_ff, d1_ff, d2_ff);
      link_we     = 1'b0;
      link_waddr  = link_addr(layer_ff + 1'b1, tgt_n1_ff, tgt_n2_ff);
      wt_we       = 1'b0;
      grp_we      = 1'b0;
      grp_idx     = tr_idx;
      grp_val     = lab_ff[pl_res.home];
      adv         = 1'b0;
      adv_skip    = 1'b0;

      // drain the output register when the consumer takes it
      if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               d1_in   = '0;
               d2_in   = '0;
               slot_in = '0;
               last_in = req_last_item;
               if (count_ff < LAYER_BITS'(MAX_ITEMS)) begin
                  wt_we     = 1'b1;
                  weight_in = req_weight;
                  layer_in  = count_ff;
                  state_in  = S_CLEAR;
               end else begin
                  ovf_in = 1'b1;
                  if (req_last_item) begin
                     layer_in = count_ff;
                     found_in = 1'b0;
                     state_in = S_BRD;
                  end
               end
            end
         end

         // wipe the next layer one row at a time
         S_CLEAR: begin
            reach_we = 1'b1;
            if (d1_ff == DIFF_LAST) begin
               d1_in    = '0;
               state_in = S_FRD;
            end else begin
               d1_in = d1_ff + 1'b1;
            end
         end

         S_FRD: begin
            reach_re  = 1'b1;
            layer0_in = (layer_ff == '0);
            state_in  = S_FROW;
         end

         S_FROW: begin
            row_in   = row_src;
            state_in = S_FSTEP;
         end

         // try one bin of one reachable pair; fetch the target row if kept
         S_FSTEP: begin
            if (row_ff[d2_ff] && pl_res.ok) begin
               reach_re    = 1'b1;
               reach_raddr = reach_addr(layer_ff + 1'b1, pl_res.n1);
               tgt_n1_in   = pl_res.n1;
               tgt_n2_in   = pl_res.n2;
               tgt_link_in = {d1_ff, d2_ff, slot_ff};
               state_in    = S_FWR;
            end else begin
               adv      = 1'b1;
               adv_skip = !row_ff[d2_ff];
            end
         end

         // merge the bit into the target row and record the parent
         S_FWR: begin
            reach_we    = 1'b1;
            reach_waddr = reach_addr(layer_ff + 1'b1, tgt_n1_ff);
            reach_wdata = reach_rd_ff | (MAX_DIFF'(1) << tgt_n2_ff);
            link_we     = 1'b1;
            adv         = 1'b1;
         end

         S_BRD: begin
            reach_re  = 1'b1;
            layer0_in = (layer_ff == '0);
            state_in  = S_BROW;
         end

         S_BROW: begin
            row_in   = row_src;
            state_in = S_BSTEP;
         end

         // keep the first pair with the smallest gap sum
         S_BSTEP: begin
            if (row_ff[d2_ff] && (!found_ff || pair_sum < best_ff)) begin
               found_in = 1'b1;
               best_in  = pair_sum;
               bd1_in   = d1_ff;
               bd2_in   = d2_ff;
            end
            if (d2_ff != DIFF_LAST) begin
               d2_in = d2_ff + 1'b1;
            end else begin
               d2_in = '0;
               if (d1_ff != DIFF_LAST) begin
                  d1_in    = d1_ff + 1'b1;
                  state_in = S_BRD;
               end else if (found_in) begin
                  d1_in    = bd1_in;
                  d2_in    = bd2_in;
                  lab_in   = {2'd2, 2'd1, 2'd0};
                  state_in = S_TRD;
               end else begin
                  eidx_in  = '0;
                  state_in = S_EMIT;
               end
            end
         end

         S_TRD: begin
            link_re  = 1'b1;
            state_in = S_TSTEP;
         end

         // replay the parent placement, label the item, step one layer back
         S_TSTEP: begin
            grp_we = 1'b1;
            for (int j = 0; j < BINS; j++) begin
               lab_in[j] = lab_ff[pl_res.rank[j]];
            end
            d1_in    = pl_d1;
            d2_in    = pl_d2;
            layer_in = layer_ff - 1'b1;
            if (layer_ff == LAYER_BITS'(1)) begin
               eidx_in  = '0;
               state_in = S_EMIT;
            end else begin
               state_in = S_TRD;
            end
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_idx_in    = INDEX_BITS'(eidx_ff);
               rsp_grp_in    = found_ff ? grp_ff[eidx_ff[ITEM_AW-1:0]] : 2'd0;
               rsp_spread_in = found_ff ? SPREAD_BITS'(best_ff) : '0;
               rsp_nosol_in  = !found_ff;
               rsp_ovf_in    = ovf_ff;
               rsp_last_in   = (eidx_ff == count_ff - 1'b1);
               eidx_in       = eidx_ff + 1'b1;
               if (eidx_ff == count_ff - 1'b1) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // advance over bins, gap positions and rows of the forward fill
      if (adv) begin
         if (!adv_skip && slot_ff != SLOT_LAST) begin
            slot_in  = slot_ff + 2'd1;
            state_in = S_FSTEP;
         end else begin
            slot_in = '0;
            if (d2_ff != DIFF_LAST) begin
               d2_in    = d2_ff + 1'b1;
               state_in = S_FSTEP;
            end else begin
               d2_in = '0;
               if (d1_ff != DIFF_LAST) begin
                  d1_in    = d1_ff + 1'b1;
                  state_in = S_FRD;
               end else begin
                  d1_in    = '0;
                  count_in = count_ff + 1'b1;
                  if (last_ff) begin
                     layer_in = count_ff + 1'b1;
                     found_in = 1'b0;
                     state_in = S_BRD;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      last_ff       <= last_in;
      weight_ff     <= weight_in;
      layer_ff      <= layer_in;
      layer0_ff     <= layer0_in;
      d1_ff         <= d1_in;
      d2_ff         <= d2_in;
      slot_ff       <= slot_in;
      row_ff        <= row_in;
      tgt_n1_ff     <= tgt_n1_in;
      tgt_n2_ff     <= tgt_n2_in;
      tgt_link_ff   <= tgt_link_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      bd1_ff        <= bd1_in;
      bd2_ff        <= bd2_in;
      lab_ff        <= lab_in;
      eidx_ff       <= eidx_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_grp_ff    <= rsp_grp_in;
      rsp_spread_ff <= rsp_spread_in;
      rsp_nosol_ff  <= rsp_nosol_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // weight and group stores
   always_ff @(posedge clock) begin
      if (wt_we) begin
         weights_ff[count_ff[ITEM_AW-1:0]] <= req_weight;
      end
      if (grp_we) begin
         grp_ff[grp_idx] <= grp_val;
      end
   end

   // reach rows: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (reach_we) begin
         reach_mem[reach_waddr] <= reach_wdata;
      end
      if (reach_re) begin
         reach_rd_ff <= reach_mem[reach_raddr];
      end
   end

   // parent links: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= tgt_link_ff;
      end
      if (link_re) begin
         link_rd_ff <= link_mem[link_raddr];
      end
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_item_index  = rsp_idx_ff;
   assign rsp_group       = rsp_grp_ff;
   assign rsp_spread      = rsp_spread_ff;
   assign rsp_no_solution = rsp_nosol_ff;
   assign rsp_overflow    = rsp_ovf_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

[rtl/twp_checker.sv]
module twp_checker import twp_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [INDEX_BITS-1:0]  rsp_item_index,
   input logic [GROUP_BITS-1:0]  rsp_group,
   input logic [SPREAD_BITS-1:0] rsp_spread,
   input logic                   rsp_no_solution,
   input logic                   rsp_overflow,
   input logic                   rsp_last_result
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_item_index) && $stable(rsp_group)
         && $stable(rsp_spread) && $stable(rsp_no_solution) && $stable(rsp_overflow)
         && $stable(rsp_last_result))
      else $error("stalled response changed");

   // a run without a solution reports neutral fields
   a_nosol: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_solution |-> rsp_group == 2'd0 && rsp_spread == '0)
      else $error("no-solution response carries a partition");

   // only three groups exist
   a_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_group != 2'd3)
      else $error("group out of range");

endmodule

bind three_way_partition_dp twp_checker u_twp_checker (.*);
